@@ rtl/core/vfx_pkg.sv @@
`timescale 1ns / 1ps

package vfx_pkg;

	typedef logic [3:0] kind_t;

	localparam kind_t KIND_ADD      = 4'd0;
	localparam kind_t KIND_SUB      = 4'd1;
	localparam kind_t KIND_NEGATE   = 4'd2;
	localparam kind_t KIND_SCALE    = 4'd3;
	localparam kind_t KIND_MAG      = 4'd4;
	localparam kind_t KIND_NORM     = 4'd5;
	localparam kind_t KIND_DOT      = 4'd6;
	localparam kind_t KIND_CROSS    = 4'd7;
	localparam kind_t KIND_HADAMARD = 4'd8;

	localparam int LANES    = 4;
	localparam int TOL_BITS = 16;

	typedef struct packed {
		logic eq;
		logic sat;
	} lane_flags_t;

endpackage

@@ rtl/core/vfx_lane.sv @@
`timescale 1ns / 1ps

module vfx_lane import vfx_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  kind_t                         kind,
	input  logic signed [WORD_BITS-1:0]   a,
	input  logic signed [WORD_BITS-1:0]   b,
	input  logic signed [WORD_BITS-1:0]   scale,
	input  logic signed [WORD_BITS-1:0]   cx_a,
	input  logic signed [WORD_BITS-1:0]   cx_b,
	input  logic signed [WORD_BITS-1:0]   cy_a,
	input  logic signed [WORD_BITS-1:0]   cy_b,
	input  logic [TOL_BITS-1:0]           tol,
	output logic signed [2*WORD_BITS:0]   lv,
	output logic signed [WORD_BITS-1:0]   r,
	output lane_flags_t                   flags,
	output logic [WORD_BITS-1:0]          mag,
	output logic                          neg
);

	localparam int W  = WORD_BITS;
	localparam int PW = 2 * WORD_BITS;
	localparam int RW = 2 * WORD_BITS + 1;
	localparam logic signed [RW:0] HALF = (RW + 1)'(1) << (FRAC_BITS - 1);
	localparam logic [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};

	logic signed [W-1:0]  mx, my;
	logic signed [W:0]    ew, dif;
	logic [W:0]           adif;

	logic signed [PW-1:0] p0_s2, p1_s2;
	logic signed [W:0]    ew_s2, ew_s3;
	logic                 eq_s2, eq_s3, eq_s4;
	kind_t                kind_s2, kind_s3;
	logic [W-1:0]         mag_s2, mag_s3, mag_s4;
	logic                 neg_s2, neg_s3, neg_s4;
	logic signed [RW-1:0] lv_s3;
	logic signed [W-1:0]  r_s4;
	logic                 sat_s4;

	logic signed [RW:0]   rsum, rnd;
	logic                 rnd_fit, ew_fit;
	logic [W-1:0]         rnd_val, ew_val, r_n;
	logic                 sat_n;

	always_comb begin
		mx = (kind == KIND_CROSS) ? cx_a : a;
		case (kind)
			KIND_SCALE:          my = scale;
			KIND_MAG, KIND_NORM: my = a;
			KIND_CROSS:          my = cx_b;
			default:             my = b;
		endcase
	end

	always_comb begin
		case (kind)
			KIND_ADD:    ew = $signed({a[W-1], a}) + $signed({b[W-1], b});
			KIND_SUB:    ew = $signed({a[W-1], a}) - $signed({b[W-1], b});
			KIND_NEGATE: ew = -$signed({a[W-1], a});
			default:     ew = '0;
		endcase
	end

	assign dif  = $signed({a[W-1], a}) - $signed({b[W-1], b});
	assign adif = dif[W] ? $unsigned(-dif) : $unsigned(dif);

	always_ff @(posedge clk) begin
		p0_s2   <= mx * my;
		p1_s2   <= cy_a * cy_b;
		ew_s2   <= ew;
		eq_s2   <= adif <= (W + 1)'(tol);
		kind_s2 <= kind;
		mag_s2  <= a[W-1] ? $unsigned(-a) : $unsigned(a);
		neg_s2  <= a[W-1];
	end

	always_ff @(posedge clk) begin
		if (kind_s2 == KIND_CROSS) begin
			lv_s3 <= $signed({p0_s2[PW-1], p0_s2}) - $signed({p1_s2[PW-1], p1_s2});
		end else begin
			lv_s3 <= $signed({p0_s2[PW-1], p0_s2});
		end
		ew_s3   <= ew_s2;
		eq_s3   <= eq_s2;
		kind_s3 <= kind_s2;
		mag_s3  <= mag_s2;
		neg_s3  <= neg_s2;
	end

	// round half up, then clip to the word
	assign rsum    = $signed({lv_s3[RW-1], lv_s3}) + HALF;
	assign rnd     = rsum >>> FRAC_BITS;
	assign rnd_fit = (&rnd[RW:W-1]) | ~(|rnd[RW:W-1]);
	assign rnd_val = rnd_fit ? rnd[W-1:0] : (rnd[RW] ? MINV : MAXV);
	assign ew_fit  = ew_s3[W] == ew_s3[W-1];
	assign ew_val  = ew_fit ? ew_s3[W-1:0] : (ew_s3[W] ? MINV : MAXV);

	always_comb begin
		case (kind_s3)
			KIND_ADD, KIND_SUB, KIND_NEGATE: begin
				r_n   = ew_val;
				sat_n = ~ew_fit;
			end
			KIND_SCALE, KIND_CROSS, KIND_HADAMARD: begin
				r_n   = rnd_val;
				sat_n = ~rnd_fit;
			end
			default: begin
				r_n   = '0;
				sat_n = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		r_s4   <= r_n;
		sat_s4 <= sat_n;
		eq_s4  <= eq_s3;
		mag_s4 <= mag_s3;
		neg_s4 <= neg_s3;
	end

	assign lv        = lv_s3;
	assign r         = r_s4;
	assign flags.eq  = eq_s4;
	assign flags.sat = sat_s4;
	assign mag       = mag_s4;
	assign neg       = neg_s4;

endmodule

@@ rtl/core/vfx_merge.sv @@
`timescale 1ns / 1ps

module vfx_merge import vfx_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic                          clk,
	input  logic signed [2*WORD_BITS:0]   lv [LANES],
	output logic signed [2*WORD_BITS+2:0] sum
);

	localparam int SW = 2 * WORD_BITS + 3;

	logic signed [SW-1:0] sum_s4;

	always_ff @(posedge clk) begin
		sum_s4 <= SW'(lv[0]) + SW'(lv[1]) + SW'(lv[2]) + SW'(lv[3]);
	end

	assign sum = sum_s4;

endmodule

@@ rtl/core/vfx_sqrt.sv @@
`timescale 1ns / 1ps

module vfx_sqrt #(
	parameter int ROOT_BITS = 33,
	parameter int SIDE_W    = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [2*ROOT_BITS-1:0] rad,
	input  logic [SIDE_W-1:0]      side_in,
	output logic                   out_valid,
	output logic [ROOT_BITS-1:0]   root,
	output logic [SIDE_W-1:0]      side_out
);

	localparam int NB  = ROOT_BITS;
	localparam int RMW = ROOT_BITS + 3;

	logic [NB-1:0]     vld_q;
	logic [2*NB-1:0]   rad_q  [NB];
	logic [RMW-1:0]    rem_q  [NB];
	logic [NB-1:0]     root_q [NB];
	logic [SIDE_W-1:0] side_q [NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[NB-2:0], in_valid};
		end
	end

	// one root digit per stage, most significant first
	for (genvar k = 0; k < NB; k++) begin : g_stage
		logic [2*NB-1:0]   rad_i;
		logic [RMW-1:0]    rem_i, rem_sh, trial;
		logic [NB-1:0]     root_i;
		logic [SIDE_W-1:0] side_i;

		if (k == 0) begin : g_first
			assign rad_i  = rad;
			assign rem_i  = '0;
			assign root_i = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign rad_i  = rad_q[k-1];
			assign rem_i  = rem_q[k-1];
			assign root_i = root_q[k-1];
			assign side_i = side_q[k-1];
		end

		assign rem_sh = {rem_i[RMW-3:0], rad_i[2*(NB-1-k)+1 -: 2]};
		assign trial  = RMW'({root_i, 2'b01});

		always_ff @(posedge clk) begin
			rad_q[k]  <= rad_i;
			side_q[k] <= side_i;
			if (rem_sh >= trial) begin
				rem_q[k]  <= rem_sh - trial;
				root_q[k] <= {root_i[NB-2:0], 1'b1};
			end else begin
				rem_q[k]  <= rem_sh;
				root_q[k] <= {root_i[NB-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_q[NB-1];
	assign root      = root_q[NB-1];
	assign side_out  = side_q[NB-1];

endmodule

@@ rtl/core/vfx_div.sv @@
`timescale 1ns / 1ps

module vfx_div import vfx_pkg::*; #(
	parameter int NUM_W  = 49,
	parameter int DEN_W  = 33,
	parameter int Q_BITS = 17,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num [LANES],
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [Q_BITS-1:0] quo [LANES],
	output logic [SIDE_W-1:0] side_out
);

	logic [Q_BITS-1:0] vld_q;
	logic [NUM_W-1:0]  rem_q  [Q_BITS][LANES];
	logic [Q_BITS-1:0] q_q    [Q_BITS][LANES];
	logic [DEN_W-1:0]  den_q  [Q_BITS];
	logic [SIDE_W-1:0] side_q [Q_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[Q_BITS-2:0], in_valid};
		end
	end

	// restoring division, one quotient bit per stage and lane
	for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
		localparam int QB = Q_BITS - 1 - k;
		logic [DEN_W-1:0]  den_i;
		logic [SIDE_W-1:0] side_i;
		logic [NUM_W-1:0]  dsh;

		if (k == 0) begin : g_first
			assign den_i  = den;
			assign side_i = side_in;
		end else begin : g_next
			assign den_i  = den_q[k-1];
			assign side_i = side_q[k-1];
		end

		assign dsh = NUM_W'(den_i) << QB;

		always_ff @(posedge clk) begin
			den_q[k]  <= den_i;
			side_q[k] <= side_i;
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [NUM_W-1:0]  rem_i;
			logic [Q_BITS-1:0] q_i, q_n;
			logic              ge;

			if (k == 0) begin : g_first
				assign rem_i = num[l];
				assign q_i   = '0;
			end else begin : g_next
				assign rem_i = rem_q[k-1][l];
				assign q_i   = q_q[k-1][l];
			end

			assign ge = rem_i >= dsh;

			always_comb begin
				q_n     = q_i;
				q_n[QB] = ge;
			end

			always_ff @(posedge clk) begin
				rem_q[k][l] <= ge ? rem_i - dsh : rem_i;
				q_q[k][l]   <= q_n;
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_quo
		assign quo[l] = q_q[Q_BITS-1][l];
	end

	assign out_valid = vld_q[Q_BITS-1];
	assign side_out  = side_q[Q_BITS-1];

endmodule

@@ rtl/core/four_component_vector_alu_core.sv @@
`timescale 1ns / 1ps

// Four-component vector unit, signed fixed point (WORD_BITS wide, FRAC_BITS fraction).
// Items enter on start when busy is low; busy stays low, so one item can enter
// every clock cycle and the pipe holds up to one item in each of its stages.
// Each item gives exactly one result: r_x..r_w, scalar_out and the three flags
// show for one cycle with done high. The pipe is four stages of lane multiply,
// combine and merge, then the pipelined square root, one root digit per stage,
// then the per-lane divider of normalize, one quotient bit per stage, and the
// output register.
// Every operation goes through the full pipe, so results leave in entry order.
// The receiver takes each result in its done cycle and cannot stall the pipe.
// The tolerance register is written on cfg_valid, cfg_ready is always high;
// write it only while no item is in flight.
// Reset empties the pipe (no done until new items arrive) and sets the
// tolerance to one.
module four_component_vector_alu_core import vfx_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  kind_t                       kind,
	input  logic signed [WORD_BITS-1:0] a_x,
	input  logic signed [WORD_BITS-1:0] a_y,
	input  logic signed [WORD_BITS-1:0] a_z,
	input  logic signed [WORD_BITS-1:0] a_w,
	input  logic signed [WORD_BITS-1:0] b_x,
	input  logic signed [WORD_BITS-1:0] b_y,
	input  logic signed [WORD_BITS-1:0] b_z,
	input  logic signed [WORD_BITS-1:0] b_w,
	input  logic signed [WORD_BITS-1:0] scale_factor,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [TOL_BITS-1:0]         cfg_data,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] r_x,
	output logic signed [WORD_BITS-1:0] r_y,
	output logic signed [WORD_BITS-1:0] r_z,
	output logic signed [WORD_BITS-1:0] r_w,
	output logic signed [WORD_BITS-1:0] scalar_out,
	output logic                        vectors_equal,
	output logic                        saturated,
	output logic                        zero_length
);

	localparam int W      = WORD_BITS;
	localparam int SW     = 2 * WORD_BITS + 3;
	localparam int NUM_W  = WORD_BITS + FRAC_BITS + 1;
	localparam int Q_BITS = FRAC_BITS + 1;
	localparam int EW     = ((Q_BITS > W) ? Q_BITS : W) + 1;
	localparam int SQ_SIDE = 4 + LANES * 2 + LANES * W + LANES * W + LANES + SW;
	localparam int DV_SIDE = 4 + LANES * 2 + LANES * W + LANES + SW + W + 1;
	localparam int LAT    = WORD_BITS + FRAC_BITS + 7;
	localparam logic [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};
	localparam logic signed [SW-1:0] DHALF = SW'(1) << (FRAC_BITS - 1);
	localparam logic [EW-1:0] QLIM = EW'(1) << (W - 1);

	logic [TOL_BITS-1:0]        tol_q;
	logic                       v_s1, v_s2, v_s3, v_s4;
	kind_t                      kind_s1, kind_s2, kind_s3, kind_s4;
	logic [LANES-1:0][W-1:0]    a_s1, b_s1;
	logic signed [W-1:0]        s_s1;

	logic signed [2*W:0]        lv_l [LANES];
	logic [LANES-1:0][W-1:0]    r_l, mag_l;
	lane_flags_t [LANES-1:0]    fl_l;
	logic [LANES-1:0]           neg_l;
	logic signed [SW-1:0]       dsum_s4;

	logic                       sq_valid;
	logic [W:0]                 m_sq;
	logic [SQ_SIDE-1:0]         sq_side;
	kind_t                      kind_sq;
	lane_flags_t [LANES-1:0]    fl_sq;
	logic [LANES-1:0][W-1:0]    r_sq, mag_sq;
	logic [LANES-1:0]           neg_sq;
	logic signed [SW-1:0]       dsum_sq;
	logic [NUM_W-1:0]           num_l [LANES];

	logic                       dv_valid;
	logic [Q_BITS-1:0]          q_l [LANES];
	logic [DV_SIDE-1:0]         dv_side;
	kind_t                      kind_f;
	lane_flags_t [LANES-1:0]    fl_f;
	logic [LANES-1:0][W-1:0]    r_f;
	logic [LANES-1:0]           neg_f;
	logic signed [SW-1:0]       dsum_f;
	logic [W:0]                 m_f;

	logic signed [SW-1:0]       dr_sum, drnd;
	logic                       d_fit, m_ovf, zl_n, eq_n, sat_n;
	logic [W-1:0]               d_val, m_val, sc_n;
	logic [LANES-1:0][W-1:0]    nq_val, r_n;
	logic [LANES-1:0]           nq_ovf, lsat;

	logic                       done_q, eq_q, sat_q, zl_q;
	logic [LANES-1:0][W-1:0]    r_q;
	logic [W-1:0]               sc_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		a_s1    <= {a_w, a_z, a_y, a_x};
		b_s1    <= {b_w, b_z, b_y, b_x};
		s_s1    <= scale_factor;
		kind_s2 <= kind_s1;
		kind_s3 <= kind_s2;
		kind_s4 <= kind_s3;
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		vfx_lane #(
			.WORD_BITS(WORD_BITS),
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk   (clk),
			.kind  (kind_s1),
			.a     (a_s1[i]),
			.b     (b_s1[i]),
			.scale (s_s1),
			.cx_a  (a_s1[(i + 1) % 3]),
			.cx_b  (b_s1[(i + 2) % 3]),
			.cy_a  (a_s1[(i + 2) % 3]),
			.cy_b  (b_s1[(i + 1) % 3]),
			.tol   (tol_q),
			.lv    (lv_l[i]),
			.r     (r_l[i]),
			.flags (fl_l[i]),
			.mag   (mag_l[i]),
			.neg   (neg_l[i])
		);
	end

	vfx_merge #(
		.WORD_BITS(WORD_BITS)
	) u_merge (
		.clk (clk),
		.lv  (lv_l),
		.sum (dsum_s4)
	);

	vfx_sqrt #(
		.ROOT_BITS(W + 1),
		.SIDE_W   (SQ_SIDE)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.rad       (dsum_s4[2*W+1:0]),
		.side_in   ({kind_s4, fl_l, r_l, mag_l, neg_l, dsum_s4}),
		.out_valid (sq_valid),
		.root      (m_sq),
		.side_out  (sq_side)
	);

	assign {kind_sq, fl_sq, r_sq, mag_sq, neg_sq, dsum_sq} = sq_side;

	for (genvar i = 0; i < LANES; i++) begin : g_num
		assign num_l[i] = (NUM_W'(mag_sq[i]) << FRAC_BITS) + NUM_W'(m_sq >> 1);
	end

	vfx_div #(
		.NUM_W (NUM_W),
		.DEN_W (W + 1),
		.Q_BITS(Q_BITS),
		.SIDE_W(DV_SIDE)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.num       (num_l),
		.den       (m_sq),
		.side_in   ({kind_sq, fl_sq, r_sq, neg_sq, dsum_sq, m_sq}),
		.out_valid (dv_valid),
		.quo       (q_l),
		.side_out  (dv_side)
	);

	assign {kind_f, fl_f, r_f, neg_f, dsum_f, m_f} = dv_side;

	assign dr_sum = dsum_f + DHALF;
	assign drnd   = dr_sum >>> FRAC_BITS;
	assign d_fit  = (&drnd[SW-1:W-1]) | ~(|drnd[SW-1:W-1]);
	assign d_val  = d_fit ? drnd[W-1:0] : (drnd[SW-1] ? MINV : MAXV);
	assign m_ovf  = m_f[W] | m_f[W-1];
	assign m_val  = m_ovf ? MAXV : m_f[W-1:0];
	assign zl_n   = m_f == '0;

	for (genvar i = 0; i < LANES; i++) begin : g_norm
		logic [EW-1:0] qe;
		assign qe        = EW'(q_l[i]);
		assign nq_ovf[i] = neg_f[i] ? (qe > QLIM) : (qe > QLIM - EW'(1));
		assign nq_val[i] = nq_ovf[i] ? (neg_f[i] ? MINV : MAXV)
			: (neg_f[i] ? W'(EW'(0) - qe) : W'(qe));
		assign lsat[i]   = fl_f[i].sat;
	end

	assign eq_n = fl_f[0].eq & fl_f[1].eq & fl_f[2].eq & fl_f[3].eq;

	always_comb begin
		r_n   = '0;
		sc_n  = '0;
		sat_n = 1'b0;
		case (kind_f)
			KIND_ADD, KIND_SUB, KIND_NEGATE, KIND_SCALE, KIND_HADAMARD: begin
				r_n   = r_f;
				sat_n = |lsat;
			end
			KIND_CROSS: begin
				r_n[0] = r_f[0];
				r_n[1] = r_f[1];
				r_n[2] = r_f[2];
				sat_n  = lsat[0] | lsat[1] | lsat[2];
			end
			KIND_MAG: begin
				sc_n  = m_val;
				sat_n = m_ovf;
			end
			KIND_NORM: begin
				if (!zl_n) begin
					r_n   = nq_val;
					sat_n = |nq_ovf;
				end
			end
			KIND_DOT: begin
				sc_n  = d_val;
				sat_n = ~d_fit;
			end
			default: begin
				sat_n = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		r_q   <= r_n;
		sc_q  <= sc_n;
		eq_q  <= eq_n;
		sat_q <= sat_n;
		zl_q  <= (kind_f == KIND_NORM) && zl_n;
	end

	assign done          = done_q;
	assign r_x           = r_q[0];
	assign r_y           = r_q[1];
	assign r_z           = r_q[2];
	assign r_w           = r_q[3];
	assign scalar_out    = sc_q;
	assign vectors_equal = eq_q;
	assign saturated     = sat_q;
	assign zero_length   = zl_q;

`ifndef SYNTH
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("item accepted without a result after the pipe latency");

	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching accepted item");

	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_length) |-> (!saturated && r_x == '0 && r_y == '0
			&& r_z == '0 && r_w == '0 && scalar_out == '0))
		else $error("zero length normalize gave a nonzero result");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (tol_q == $past(cfg_data)))
		else $error("tolerance write lost");
`endif

endmodule

@@ tb/sv/four_component_vector_alu_core_tb.sv @@
`timescale 1ns / 1ps

module four_component_vector_alu_core_tb;
	import vfx_pkg::*;

	localparam int FRAC = 16;
	localparam int WB = 32;
	localparam int LATENCY = WB + FRAC + 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic signed [31:0] MAXV = 32'sh7fffffff;
	localparam logic signed [31:0] MINV = 32'sh80000000;

	typedef struct {
		logic signed [31:0] r[4];
		logic signed [31:0] scalar;
		logic eq;
		logic sat;
		logic zl;
	} vec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	kind_t kind = KIND_ADD;
	logic signed [31:0] a_x = '0, a_y = '0, a_z = '0, a_w = '0;
	logic signed [31:0] b_x = '0, b_y = '0, b_z = '0, b_w = '0;
	logic signed [31:0] scale_factor = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [TOL_BITS-1:0] cfg_data = '0;
	logic done;
	logic signed [31:0] r_x, r_y, r_z, r_w, scalar_out;
	logic vectors_equal, saturated, zero_length;

	logic [15:0] tolerance;
	vec_result_t expected_q[$];
	int errors = 0;
	int idle_cycles = 0;

	always #4 clk = ~clk;

	four_component_vector_alu_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
		.b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
		.scale_factor(scale_factor),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w),
		.scalar_out(scalar_out), .vectors_equal(vectors_equal),
		.saturated(saturated), .zero_length(zero_length)
	);

	function automatic logic signed [31:0] clip(input logic signed [127:0] v, inout logic sat);
		if (v > 128'(MAXV)) begin
			sat = 1'b1;
			return MAXV;
		end
		if (v < 128'(MINV)) begin
			sat = 1'b1;
			return MINV;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [127:0] round_q(input logic signed [127:0] p);
		return (p + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic logic [63:0] root_floor(input logic [127:0] v);
		logic [63:0] res;
		logic [63:0] c;
		res = '0;
		for (int bt = WB; bt >= 0; bt--) begin
			c = res | (64'd1 << bt);
			if (128'(c) * 128'(c) <= v) res = c;
		end
		return res;
	endfunction

	function automatic vec_result_t vector_op(input kind_t k,
			input logic signed [31:0] a[4], input logic signed [31:0] b[4],
			input logic signed [31:0] s, input logic [15:0] tol);
		vec_result_t e;
		logic signed [127:0] wa[4], wb[4], acc, d;
		logic [127:0] sq, q;
		logic [63:0] m;
		e.r = '{default: '0};
		e.scalar = '0;
		e.sat = 1'b0;
		e.zl = 1'b0;
		e.eq = 1'b1;
		for (int i = 0; i < 4; i++) begin
			wa[i] = a[i];
			wb[i] = b[i];
			d = wa[i] - wb[i];
			if (d < 0) d = -d;
			if (d > 128'(tol)) e.eq = 1'b0;
		end
		case (k)
			KIND_ADD: for (int i = 0; i < 4; i++) e.r[i] = clip(wa[i] + wb[i], e.sat);
			KIND_SUB: for (int i = 0; i < 4; i++) e.r[i] = clip(wa[i] - wb[i], e.sat);
			KIND_NEGATE: for (int i = 0; i < 4; i++) e.r[i] = clip(-wa[i], e.sat);
			KIND_SCALE: for (int i = 0; i < 4; i++)
				e.r[i] = clip(round_q(wa[i] * 128'(s)), e.sat);
			KIND_MAG, KIND_NORM: begin
				sq = '0;
				for (int i = 0; i < 4; i++) sq += wa[i] * wa[i];
				m = root_floor(sq);
				if (k == KIND_MAG) begin
					e.scalar = clip(128'(m), e.sat);
				end else if (m == 0) begin
					e.zl = 1'b1;
				end else begin
					for (int i = 0; i < 4; i++) begin
						d = wa[i] < 0 ? -wa[i] : wa[i];
						q = ((d << FRAC) + (m >> 1)) / 128'(m);
						e.r[i] = clip(wa[i] < 0 ? -$signed(q) : $signed(q), e.sat);
					end
				end
			end
			KIND_DOT: begin
				acc = '0;
				for (int i = 0; i < 4; i++) acc += wa[i] * wb[i];
				e.scalar = clip(round_q(acc), e.sat);
			end
			KIND_CROSS: begin
				e.r[0] = clip(round_q(wa[1] * wb[2] - wa[2] * wb[1]), e.sat);
				e.r[1] = clip(round_q(wa[2] * wb[0] - wa[0] * wb[2]), e.sat);
				e.r[2] = clip(round_q(wa[0] * wb[1] - wa[1] * wb[0]), e.sat);
			end
			KIND_HADAMARD: for (int i = 0; i < 4; i++)
				e.r[i] = clip(round_q(wa[i] * wb[i]), e.sat);
			default: ;
		endcase
		return e;
	endfunction

	task automatic send_item(input kind_t k, input logic signed [31:0] a[4],
			input logic signed [31:0] b[4], input logic signed [31:0] s, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		kind <= k;
		a_x <= a[0]; a_y <= a[1]; a_z <= a[2]; a_w <= a[3];
		b_x <= b[0]; b_y <= b[1]; b_z <= b[2]; b_w <= b[3];
		scale_factor <= s;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_q.push_back(vector_op(k, a, b, s, tolerance));
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_tolerance(input logic [15:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tolerance = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return MAXV;
			1: return MINV;
			2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			3: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
			4: return '0;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic test_directed();
		logic signed [31:0] a[4], b[4];
		a = '{MAXV, MINV, 32'sh10000, -32'sh10000};
		b = '{MAXV, MINV, -32'sh8000, 32'sh18000};
		for (int k = 0; k < 16; k++) send_item(kind_t'(k), a, b, MINV, 1'b0);
		a = '{default: '0};
		b = '{default: '0};
		send_item(KIND_NORM, a, b, MAXV, 1'b0);
		send_item(KIND_MAG, a, b, MAXV, 1'b0);
		a = '{MINV, MINV, MINV, MINV};
		send_item(KIND_NEGATE, a, b, MAXV, 1'b0);
		send_item(KIND_MAG, a, b, MAXV, 1'b0);
		send_item(KIND_NORM, a, b, MAXV, 1'b0);
		a = '{32'sd1, 32'sd0, 32'sd0, 32'sd0};
		b = '{32'sd2, 32'sd1, -32'sd1, 32'sd0};
		send_item(KIND_NORM, a, b, 32'sd0, 1'b0);
		send_item(KIND_ADD, a, b, 32'sd0, 1'b0);
		a = '{32'sh7fff0000, 32'sh8000, 32'sh12345, 32'sh1};
		b = '{32'sh7fff0000, 32'sh8000, 32'sh12346, 32'sh0};
		send_item(KIND_CROSS, a, b, 32'sh8000, 1'b0);
		send_item(KIND_SCALE, a, b, 32'sh8000, 1'b0);
	endtask

	task automatic test_random(input int count);
		logic signed [31:0] a[4], b[4];
		kind_t k;
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 4; i++) begin
				a[i] = rand_word();
				b[i] = $urandom_range(0, 3) == 0 ? a[i] + $signed($urandom_range(0, 4))
					- 32'sd2 : rand_word();
			end
			k = $urandom_range(0, 9) == 0 ? kind_t'($urandom_range(0, 15))
				: kind_t'($urandom_range(0, 8));
			send_item(k, a, b, rand_word(), $urandom_range(0, 3) != 0);
		end
	endtask

	task automatic test_tolerance_sweep();
		logic signed [31:0] a[4], b[4];
		logic [15:0] tols[4];
		tols = '{16'd0, 16'hffff, 16'd2, 16'h8000};
		foreach (tols[t]) begin
			write_tolerance(tols[t]);
			for (int n = 0; n < 20; n++) begin
				for (int i = 0; i < 4; i++) begin
					a[i] = rand_word();
					b[i] = a[i] + $signed(32'(tols[t])) + $signed($urandom_range(0, 2)) - 32'sd1;
				end
				send_item(kind_t'($urandom_range(0, 8)), a, b, rand_word(), 1'b1);
			end
		end
	endtask

	always @(posedge clk) begin
		vec_result_t e;
		if (done) begin
			if (expected_q.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (r_x !== e.r[0]) begin
					$error("r_x exp %h got %h", e.r[0], r_x); errors++;
				end
				if (r_y !== e.r[1]) begin
					$error("r_y exp %h got %h", e.r[1], r_y); errors++;
				end
				if (r_z !== e.r[2]) begin
					$error("r_z exp %h got %h", e.r[2], r_z); errors++;
				end
				if (r_w !== e.r[3]) begin
					$error("r_w exp %h got %h", e.r[3], r_w); errors++;
				end
				if (scalar_out !== e.scalar) begin
					$error("scalar_out exp %h got %h", e.scalar, scalar_out); errors++;
				end
				if (vectors_equal !== e.eq) begin
					$error("vectors_equal exp %b got %b", e.eq, vectors_equal); errors++;
				end
				if (saturated !== e.sat) begin
					$error("saturated exp %b got %b", e.sat, saturated); errors++;
				end
				if (zero_length !== e.zl) begin
					$error("zero_length exp %b got %b", e.zl, zero_length); errors++;
				end
			end
		end
	end

	// watchdog: cycles with no item, result or tolerance write accepted
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("four_component_vector_alu_core_tb NOT OK");
			$finish;
		end
	end

	initial begin
		tolerance = 16'd1;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(700);
		test_tolerance_sweep();
		write_tolerance(16'd1);
		test_random(850);
		drain();
		if (errors == 0 && expected_q.size() == 0) begin
			$display("four_component_vector_alu_core_tb OK");
		end else begin
			$display("four_component_vector_alu_core_tb NOT OK");
		end
		$finish;
	end

endmodule
